FILE: src/wsd_pkg.sv
// Shared constants for the websocket frame deframer.
`default_nettype none
package wsd_pkg;

    localparam int BYTE_W = 8;

    // Header field masks and codes.
    localparam logic [7:0] OPCODE_MASK  = 8'h0F;
    localparam logic [7:0] MASK_BIT     = 8'h80;
    localparam logic [7:0] LEN_MASK     = 8'h7F;
    localparam logic [3:0] OPC_BINARY   = 4'h2;
    localparam logic [6:0] LEN_EXT16    = 7'd126;
    localparam logic [6:0] LEN_EXT64    = 7'd127;

    // Extended length byte counts, taken modulo 8 by the 3-bit counter.
    localparam logic [2:0] EXT16_BYTES  = 3'd2;
    localparam logic [2:0] EXT64_BYTES  = 3'd0;
    localparam logic [2:0] KEY_BYTES    = 3'd4;

endpackage
`default_nettype wire

FILE: src/wsd_stream_if.sv
// Valid/ready stream interfaces for raw bytes in and payload bytes out.
`default_nettype none
interface wsd_in_if;
    logic                        valid;
    logic                        ready;
    logic [wsd_pkg::BYTE_W-1:0]  in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface wsd_out_if;
    logic                        valid;
    logic                        ready;
    logic [wsd_pkg::BYTE_W-1:0]  out_byte;
    logic                        frame_last;

    modport source (output valid, output out_byte, output frame_last, input ready);
    modport sink   (input valid, input out_byte, input frame_last, output ready);
endinterface
`default_nettype wire

FILE: src/websocket_frame_deframer.sv
// Websocket frame parser: strips headers and unmasks payload bytes of binary frames.
//
//   port      dir  words carried
//   i_in_ch   in   raw received bytes (in_byte)
//   o_out_ch  out  unmasked binary payload bytes (out_byte, frame_last)
//
// One byte per cycle sustained while the output is not stalled; a byte waits in the input
// register, and its result, if any, is written to the output register when the parse step advances.
// The parse step (phase update, 64-bit length count and key XOR) is the single stage
// between the input register and the output register.
// Synchronous active-low reset returns the parser to the first header byte.
// A stalled output holds its word; the input register keeps filling until the stage
// behind it cannot advance.
`default_nettype none
module websocket_frame_deframer (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    wsd_in_if.sink     i_in_ch,
    wsd_out_if.source  o_out_ch
);

    typedef enum logic [2:0] {
        PH_FIRST   = 3'd0,
        PH_SECOND  = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_KEY     = 3'd3,
        PH_PAYLOAD = 3'd4
    } t_phase;

    // Input register.
    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    // Parser state.
    t_phase      r_phase,      n_phase;
    logic [2:0]  r_hdr_cnt,    n_hdr_cnt;
    logic [63:0] r_remain,     n_remain;
    logic [6:0]  r_len_code,   n_len_code;
    logic [31:0] r_mask_key,   n_mask_key;
    logic        r_mask_on,    n_mask_on;
    logic [1:0]  r_mask_idx,   n_mask_idx;
    logic        r_binary,     n_binary;

    // Output register.
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;

    logic        s_go;
    logic        s_emit;
    logic [7:0]  s_key_byte;
    logic [2:0]  s_cnt_inc;
    logic [2:0]  s_need;

    assign s_go           = r_in_valid && (!r_out_valid || o_out_ch.ready);
    assign i_in_ch.ready  = !r_in_valid || s_go;

    assign o_out_ch.valid      = r_out_valid;
    assign o_out_ch.out_byte   = r_out_byte;
    assign o_out_ch.frame_last = r_out_last;

    assign s_cnt_inc = r_hdr_cnt + 3'd1;
    assign s_need    = (r_len_code == wsd_pkg::LEN_EXT16) ? wsd_pkg::EXT16_BYTES
                                                          : wsd_pkg::EXT64_BYTES;

    always_comb begin
        case (r_mask_idx)
            2'd0:    s_key_byte = r_mask_key[31:24];
            2'd1:    s_key_byte = r_mask_key[23:16];
            2'd2:    s_key_byte = r_mask_key[15:8];
            default: s_key_byte = r_mask_key[7:0];
        endcase
    end

    always_comb begin
        n_phase    = r_phase;
        n_hdr_cnt  = r_hdr_cnt;
        n_remain   = r_remain;
        n_len_code = r_len_code;
        n_mask_key = r_mask_key;
        n_mask_on  = r_mask_on;
        n_mask_idx = r_mask_idx;
        n_binary   = r_binary;
        s_emit     = 1'b0;
        case (r_phase)
            PH_SECOND: begin
                n_mask_on  = (r_in_byte & wsd_pkg::MASK_BIT) != 8'd0;
                n_len_code = r_in_byte[6:0] & wsd_pkg::LEN_MASK[6:0];
                n_hdr_cnt  = 3'd0;
                if (n_len_code == wsd_pkg::LEN_EXT16 || n_len_code == wsd_pkg::LEN_EXT64) begin
                    n_remain = 64'd0;
                    n_phase  = PH_EXTLEN;
                end else begin
                    n_remain   = {57'd0, n_len_code};
                    n_mask_key = 32'd0;
                    n_mask_idx = 2'd0;
                    if (n_mask_on) begin
                        n_phase = PH_KEY;
                    end else if (n_remain != 64'd0) begin
                        n_phase = PH_PAYLOAD;
                    end else begin
                        n_phase = PH_FIRST;
                    end
                end
            end
            PH_EXTLEN: begin
                n_remain  = {r_remain[55:0], r_in_byte};
                n_hdr_cnt = s_cnt_inc;
                if (s_cnt_inc == s_need) begin
                    n_hdr_cnt  = 3'd0;
                    n_mask_key = 32'd0;
                    n_mask_idx = 2'd0;
                    if (r_mask_on) begin
                        n_phase = PH_KEY;
                    end else if (n_remain != 64'd0) begin
                        n_phase = PH_PAYLOAD;
                    end else begin
                        n_phase = PH_FIRST;
                    end
                end
            end
            PH_KEY: begin
                n_mask_key = {r_mask_key[23:0], r_in_byte};
                n_hdr_cnt  = s_cnt_inc;
                if (s_cnt_inc == wsd_pkg::KEY_BYTES) begin
                    n_hdr_cnt = 3'd0;
                    n_phase   = (r_remain != 64'd0) ? PH_PAYLOAD : PH_FIRST;
                end
            end
            PH_PAYLOAD: begin
                n_mask_idx = r_mask_idx + 2'd1;
                n_remain   = r_remain - 64'd1;
                if (r_remain == 64'd1) begin
                    n_phase = PH_FIRST;
                end
                s_emit = r_binary;
            end
            default: begin
                // The first header byte, and any unused phase code, reads the opcode.
                n_binary = (r_in_byte & wsd_pkg::OPCODE_MASK) == {4'd0, wsd_pkg::OPC_BINARY};
                n_phase  = PH_SECOND;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_FIRST;
            r_hdr_cnt   <= 3'd0;
            r_remain    <= 64'd0;
            r_len_code  <= 7'd0;
            r_mask_key  <= 32'd0;
            r_mask_on   <= 1'b0;
            r_mask_idx  <= 2'd0;
            r_binary    <= 1'b0;
        end else begin
            if (i_in_ch.ready) begin
                r_in_valid <= i_in_ch.valid;
            end
            if (o_out_ch.ready || !r_out_valid) begin
                r_out_valid <= s_go && s_emit;
            end
            if (s_go) begin
                r_phase    <= n_phase;
                r_hdr_cnt  <= n_hdr_cnt;
                r_remain   <= n_remain;
                r_len_code <= n_len_code;
                r_mask_key <= n_mask_key;
                r_mask_on  <= n_mask_on;
                r_mask_idx <= n_mask_idx;
                r_binary   <= n_binary;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_in_ch.ready && i_in_ch.valid) begin
            r_in_byte <= i_in_ch.in_byte;
        end
        if (s_go && s_emit) begin
            r_out_byte <= r_in_byte ^ s_key_byte;
            r_out_last <= (r_remain == 64'd1);
        end
    end

endmodule
`default_nettype wire

FILE: test/websocket_frame_deframer_tb.sv
// Self-checking testbench for the websocket frame deframer: frame stimulus, prediction, checks.
`default_nettype none
module websocket_frame_deframer_tb;

    localparam int IDLE_LIMIT   = 2000;
    localparam int BYTE_BUDGET  = 550;
    localparam int FILL_RANDOM  = -1;

    typedef enum logic [2:0] {
        PH_FIRST   = 3'd0,
        PH_SECOND  = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_KEY     = 3'd3,
        PH_PAYLOAD = 3'd4
    } t_parse_phase;

    typedef enum int {FORM_SHORT, FORM_EXT16, FORM_EXT64} t_len_form;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_payload_word;

    // Tracks the frame parser state and holds the payload words it should emit.
    class deframe_scoreboard;
        t_parse_phase  phase;
        logic [2:0]    hdr_count;
        logic [63:0]   bytes_left;
        logic [6:0]    len_code;
        logic [31:0]   key;
        logic          masked;
        logic [1:0]    key_pos;
        logic          is_binary;
        t_payload_word expected_q[$];
        int            mismatches;
        int            checked;
        int            dropped;

        function new();
            phase      = PH_FIRST;
            hdr_count  = '0;
            bytes_left = '0;
            len_code   = '0;
            key        = '0;
            masked     = 1'b0;
            key_pos    = '0;
            is_binary  = 1'b0;
            mismatches = 0;
            checked    = 0;
            dropped    = 0;
        endfunction

        function void length_known();
            hdr_count = '0;
            key       = '0;
            key_pos   = '0;
            if (masked)
                phase = PH_KEY;
            else if (bytes_left != 0)
                phase = PH_PAYLOAD;
            else
                phase = PH_FIRST;
        endfunction

        function void note_rx_byte(logic [7:0] b);
            t_payload_word w;
            logic [7:0]    kb;
            case (phase)
                PH_SECOND: begin
                    masked     = b[7];
                    len_code   = 7'(b & wsd_pkg::LEN_MASK);
                    bytes_left = '0;
                    hdr_count  = '0;
                    if (len_code == wsd_pkg::LEN_EXT16 || len_code == wsd_pkg::LEN_EXT64) begin
                        phase = PH_EXTLEN;
                    end else begin
                        bytes_left = 64'(len_code);
                        length_known();
                    end
                end
                PH_EXTLEN: begin
                    bytes_left = {bytes_left[55:0], b};
                    hdr_count  = hdr_count + 3'd1;
                    // A 64-bit length ends when the 3-bit count wraps to zero.
                    if (hdr_count == ((len_code == wsd_pkg::LEN_EXT16) ? wsd_pkg::EXT16_BYTES
                                                                      : wsd_pkg::EXT64_BYTES))
                        length_known();
                end
                PH_KEY: begin
                    key       = {key[23:0], b};
                    hdr_count = hdr_count + 3'd1;
                    if (hdr_count == wsd_pkg::KEY_BYTES) begin
                        hdr_count = '0;
                        phase = (bytes_left != 0) ? PH_PAYLOAD : PH_FIRST;
                    end
                end
                PH_PAYLOAD: begin
                    kb         = key[8 * (3 - key_pos) +: 8];
                    w.data     = b ^ kb;
                    key_pos    = key_pos + 2'd1;
                    bytes_left = bytes_left - 64'd1;
                    w.last     = (bytes_left == 0);
                    if (w.last)
                        phase = PH_FIRST;
                    if (is_binary)
                        expected_q.push_back(w);
                    else
                        dropped++;
                end
                default: begin
                    is_binary = ((b & wsd_pkg::OPCODE_MASK) == {4'h0, wsd_pkg::OPC_BINARY});
                    phase     = PH_SECOND;
                end
            endcase
        endfunction

        function void check_payload(logic [7:0] data, logic last);
            t_payload_word w;
            checked++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected payload word: data %02h last %0b", data, last);
            end else begin
                w = expected_q.pop_front();
                if (data !== w.data || last !== w.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"payload mismatch: expected data %02h last %0b, ",
                                  "got data %02h last %0b"},
                                 w.data, w.last, data, last);
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic calm;
    int   bytes_sent;
    int   frames_sent;
    int   drain_waits;
    int   idle_cycles;

    wsd_in_if  in_ch();
    wsd_out_if out_ch();

    deframe_scoreboard sb = new();

    websocket_frame_deframer u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one; none during a calm stretch.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Presents one byte and returns right after the edge that accepts it.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_rx_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [7:0] head, input logic masked,
                              input t_len_form form,
                              input logic [63:0] length, input logic [31:0] key,
                              input int n_payload, input int fill);
        send_byte(head);
        case (form)
            FORM_SHORT: begin
                send_byte({masked, length[6:0]});
            end
            FORM_EXT16: begin
                send_byte({masked, wsd_pkg::LEN_EXT16});
                send_byte(length[15:8]);
                send_byte(length[7:0]);
            end
            default: begin
                send_byte({masked, wsd_pkg::LEN_EXT64});
                for (int i = 7; i >= 0; i--)
                    send_byte(length[8 * i +: 8]);
            end
        endcase
        if (masked)
            for (int i = 3; i >= 0; i--)
                send_byte(key[8 * i +: 8]);
        for (int i = 0; i < n_payload; i++)
            send_byte((fill == FILL_RANDOM) ? 8'($urandom) : 8'(fill));
        frames_sent++;
    endtask

    // Returns how many bytes the frame takes on the link.
    task automatic send_random_frame(output int counted);
        logic [7:0]  head;
        logic        masked;
        t_len_form   form;
        logic [63:0] length;
        logic [31:0] key;
        int          r;
        int          hdr_len;
        if ($urandom_range(0, 9) < 6)
            head = {4'($urandom), wsd_pkg::OPC_BINARY};
        else
            head = 8'($urandom);
        masked = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 99);
        if (r < 6) begin
            form   = FORM_EXT16;
            length = 64'($urandom_range(0, 300));
        end else if (r < 10) begin
            form   = FORM_EXT64;
            length = 64'($urandom_range(0, 200));
        end else if (r < 14) begin
            form   = FORM_SHORT;
            length = $urandom_range(0, 1) ? 64'd125 : 64'd0;
        end else begin
            form   = FORM_SHORT;
            length = 64'($urandom_range(0, 24));
        end
        r = $urandom_range(0, 9);
        key = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : 32'($urandom);
        hdr_len = 2 + (form == FORM_EXT16 ? 2 : form == FORM_EXT64 ? 8 : 0)
                    + (masked ? 4 : 0);
        send_frame(head, masked, form, length, key, int'(length), FILL_RANDOM);
        counted = hdr_len + int'(length);
    endtask

    // Holds the sender off until every predicted payload word has come out.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_q.size() != 0);
        drain_waits++;
    endtask

    // Output side stalls at random.
    initial begin
        int stall;
        stall = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                stall--;
            end else begin
                out_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_payload(out_ch.out_byte, out_ch.frame_last);
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int counted;
        int budget;
        idle_cycles   = 0;
        bytes_sent    = 0;
        frames_sent   = 0;
        drain_waits   = 0;
        calm          = 1'b0;
        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.in_byte <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames: unmasked and masked binary, all-ones key, empty frames,
        // a text frame that must be dropped, both extended length forms.
        send_frame(8'h82, 1'b0, FORM_SHORT, 64'd1, 32'h0, 1, 8'hFF);
        send_frame(8'hF2, 1'b1, FORM_SHORT, 64'd3, 32'hFFFF_FFFF, 3, 8'hFF);
        send_frame(8'h02, 1'b1, FORM_SHORT, 64'd5, 32'hA5C3_0F96, 5, FILL_RANDOM);
        send_frame(8'h82, 1'b0, FORM_SHORT, 64'd0, 32'h0, 0, FILL_RANDOM);
        send_frame(8'h82, 1'b1, FORM_SHORT, 64'd0, 32'h1234_5678, 0, FILL_RANDOM);
        send_frame(8'h81, 1'b0, FORM_SHORT, 64'd2, 32'h0, 2, 8'h00);
        send_frame(8'h02, 1'b0, FORM_EXT16, 64'd2, 32'h0, 2, 8'h00);
        send_frame(8'h82, 1'b0, FORM_EXT64, 64'd0, 32'h0, 0, FILL_RANDOM);
        wait_drained();

        budget = bytes_sent;
        while (budget < BYTE_BUDGET) begin
            calm = ($urandom_range(0, 4) == 0);
            send_random_frame(counted);
            budget += counted;
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end
        calm = 1'b0;

        // A 64-bit length with its top bit set never finishes, so it goes last.
        send_frame(8'h82, 1'b0, FORM_EXT64, 64'h8000_0000_0000_0000, 32'h0, 16, FILL_RANDOM);

        in_ch.valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        $display("Sent %0d frames in %0d bytes; %0d payload words checked,",
                 frames_sent, bytes_sent, sb.checked);
        $display("%0d payload bytes dropped, %0d drain pauses, %0d mismatches, %0d missing.",
                 sb.dropped, drain_waits, sb.mismatches, sb.expected_q.size());
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
`default_nettype wire
